FILE: src/tdp_pkg.sv
// shared types, constants and register indexes for the trapezoid drive profile
package tdp_pkg;

    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    localparam int ENC_W     = 20;
    localparam int TARGET_W  = 20;
    localparam int RAMP_W    = 16;
    localparam int BREAK_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // sum of four magnitudes, each up to 2^19
    localparam int SUM_W     = ENC_W + 2;
    localparam int DIVISOR_W = RAMP_W + 2;
    localparam int DIVIDEND_W = SUM_W + 7;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BREAK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_CW    = 3'd5;

    localparam logic [7:0] INIT_CMD  = 8'd20;
    localparam logic [7:0] PEAK_CMD  = 8'd127;
    localparam logic [6:0] RAMP_GAIN = 7'd107;

    localparam logic [BREAK_W-1:0] BREAK_RESET = 7'd30;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: src/trapezoid_drive_profile_top.sv
// trapezoid drive profile: sequencer, shared adder, multiplier and divider
// a start word goes straight to the output step; cruise and done ticks first sum the magnitudes and test the phase
// a ramp tick sums the four magnitudes through one adder, tests the phase, multiplies, loads the divider,
// waits for the bit-serial divider (29 quotient bits and its done pulse), then registers the output
// one word in flight; the next word is taken the cycle after the result is registered
// reset (async, active low) restores register defaults and the done phase
module trapezoid_drive_profile_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tdp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tdp_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic signed [tdp_pkg::ENC_W-1:0]     enc_left_front,
    input  logic signed [tdp_pkg::ENC_W-1:0]     enc_left_back,
    input  logic signed [tdp_pkg::ENC_W-1:0]     enc_right_front,
    input  logic signed [tdp_pkg::ENC_W-1:0]     enc_right_back,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [7:0]                    left_drive,
    output logic signed [7:0]                    right_drive,
    output logic [1:0]                           phase,
    output logic                                 done_res
);

    localparam int SW = tdp_pkg::SUM_W;
    localparam int QW = tdp_pkg::DIVIDEND_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_EVAL,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        M_START,
        M_ACCEL,
        M_CRUISE,
        M_DECEL,
        M_ZERO
    } mode_t;

    // configuration registers
    logic [tdp_pkg::TARGET_W-1:0] target_reg;
    logic                         reverse_reg;
    logic [tdp_pkg::RAMP_W-1:0]   ramp_reg;
    logic [tdp_pkg::BREAK_W-1:0]  break_reg;
    logic                         turn_mode_reg;
    logic                         turn_cw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            reverse_reg   <= 1'b0;
            ramp_reg      <= tdp_pkg::RAMP_W'(1);
            break_reg     <= tdp_pkg::BREAK_RESET;
            turn_mode_reg <= 1'b0;
            turn_cw_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tdp_pkg::REG_TARGET:    target_reg    <= cfg_wdata[tdp_pkg::TARGET_W-1:0];
                tdp_pkg::REG_REVERSE:   reverse_reg   <= cfg_wdata[0];
                tdp_pkg::REG_RAMP:      ramp_reg      <= cfg_wdata[tdp_pkg::RAMP_W-1:0];
                tdp_pkg::REG_BREAK:     break_reg     <= cfg_wdata[tdp_pkg::BREAK_W-1:0];
                tdp_pkg::REG_TURN_MODE: turn_mode_reg <= cfg_wdata[0];
                tdp_pkg::REG_TURN_CW:   turn_cw_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    state_t                      state_reg;
    mode_t                       mode_reg;
    tdp_pkg::phase_t             profile_phase_reg;
    tdp_pkg::phase_t             pend_phase_reg;
    logic [tdp_pkg::ENC_W-1:0]   enc_reg [4];
    logic [1:0]                  cnt_reg;
    logic [SW-1:0]               sum_reg;
    logic [SW-1:0]               num_reg;
    logic [QW-1:0]               prod_reg;
    logic                        out_valid_reg;
    logic [7:0]                  left_reg;
    logic [7:0]                  right_reg;
    tdp_pkg::phase_t             phase_reg;

    logic                        in_fire;
    logic                        fin_go;
    logic [tdp_pkg::ENC_W-1:0]   enc_sel;
    logic [tdp_pkg::ENC_W-1:0]   mag_sel;
    logic [tdp_pkg::RAMP_W-1:0]  ramp_eff;
    logic [tdp_pkg::DIVISOR_W-1:0] r4;
    logic [SW-1:0]               t4;
    logic                        cond_a;
    logic                        cond_c;
    logic                        cond_d;
    logic [QW-1:0]               quotient;
    tdp_pkg::div_stat_t          div_stat;
    logic                        div_start;
    logic                        moving;
    logic [7:0]                  mag8;
    logic [7:0]                  cmd;
    logic [7:0]                  left_next;
    logic [7:0]                  right_next;
    tdp_pkg::phase_t             phase_next;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign div_start = (state_reg == S_LOAD);

    // one magnitude per cycle through the shared adder
    always_comb
    begin
        enc_sel = enc_reg[cnt_reg];
        mag_sel = enc_sel[tdp_pkg::ENC_W-1] ? (~enc_sel + tdp_pkg::ENC_W'(1)) : enc_sel;
    end

    always_comb
    begin
        ramp_eff = (ramp_reg == '0) ? tdp_pkg::RAMP_W'(1) : ramp_reg;
        r4       = {ramp_eff, 2'b00};
        t4       = {target_reg, 2'b00};
        cond_a   = (sum_reg < SW'(r4)) && (sum_reg <= {1'b0, target_reg, 1'b0});
        cond_c   = ({1'b0, sum_reg} + (SW+1)'(r4)) <= {1'b0, t4};
        cond_d   = sum_reg < t4;
    end

    tdp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (r4),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // final command shaping
    always_comb
    begin
        moving     = 1'b0;
        mag8       = '0;
        phase_next = pend_phase_reg;
        case (mode_reg)
            M_START:
            begin
                phase_next = tdp_pkg::PH_ACCEL;
            end
            M_ACCEL:
            begin
                moving = 1'b1;
                mag8   = tdp_pkg::INIT_CMD + quotient[7:0];
            end
            M_CRUISE:
            begin
                moving = 1'b1;
                mag8   = tdp_pkg::PEAK_CMD;
            end
            M_DECEL:
            begin
                if (quotient <= QW'(break_reg))
                begin
                    phase_next = tdp_pkg::PH_DONE;
                end
                else
                begin
                    moving = 1'b1;
                    mag8   = quotient[7:0];
                end
            end
            default:
            begin
                phase_next = tdp_pkg::PH_DONE;
            end
        endcase
        cmd = reverse_reg ? mag8 : (8'd0 - mag8);
        if (!moving)
        begin
            left_next  = '0;
            right_next = '0;
        end
        else if (!turn_mode_reg)
        begin
            left_next  = cmd;
            right_next = cmd;
        end
        else if (turn_cw_reg)
        begin
            left_next  = 8'd0 - cmd;
            right_next = cmd;
        end
        else
        begin
            left_next  = cmd;
            right_next = 8'd0 - cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mode_reg          <= M_ZERO;
            profile_phase_reg <= tdp_pkg::PH_DONE;
            pend_phase_reg    <= tdp_pkg::PH_DONE;
            for (int i = 0; i < 4; i++)
            begin
                enc_reg[i] <= '0;
            end
            cnt_reg           <= '0;
            sum_reg           <= '0;
            num_reg           <= '0;
            prod_reg          <= '0;
            out_valid_reg     <= 1'b0;
            left_reg          <= '0;
            right_reg         <= '0;
            phase_reg         <= tdp_pkg::PH_DONE;
        end
        else
        begin
            if (out_valid_reg && out_ready && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        enc_reg[0] <= enc_left_front;
                        enc_reg[1] <= enc_left_back;
                        enc_reg[2] <= enc_right_front;
                        enc_reg[3] <= enc_right_back;
                        cnt_reg    <= '0;
                        sum_reg    <= '0;
                        if (!action)
                        begin
                            mode_reg  <= M_START;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM:
                begin
                    sum_reg <= sum_reg + SW'(mag_sel);
                    cnt_reg <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    // a failing phase falls through to the next one in the same tick
                    if (profile_phase_reg == tdp_pkg::PH_ACCEL && cond_a)
                    begin
                        mode_reg       <= M_ACCEL;
                        pend_phase_reg <= tdp_pkg::PH_ACCEL;
                        num_reg        <= sum_reg;
                        state_reg      <= S_MUL;
                    end
                    else if ((profile_phase_reg inside {tdp_pkg::PH_ACCEL, tdp_pkg::PH_CRUISE})
                             && cond_c)
                    begin
                        mode_reg       <= M_CRUISE;
                        pend_phase_reg <= tdp_pkg::PH_CRUISE;
                        state_reg      <= S_FIN;
                    end
                    else if (profile_phase_reg != tdp_pkg::PH_DONE && cond_d)
                    begin
                        mode_reg       <= M_DECEL;
                        pend_phase_reg <= tdp_pkg::PH_DECEL;
                        num_reg        <= t4 - sum_reg;
                        state_reg      <= S_MUL;
                    end
                    else
                    begin
                        mode_reg       <= M_ZERO;
                        pend_phase_reg <= tdp_pkg::PH_DONE;
                        state_reg      <= S_FIN;
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= QW'(num_reg) * QW'(tdp_pkg::RAMP_GAIN);
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        out_valid_reg     <= 1'b1;
                        left_reg          <= left_next;
                        right_reg         <= right_next;
                        phase_reg         <= phase_next;
                        profile_phase_reg <= phase_next;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign phase       = phase_reg;
    assign done_res    = (phase_reg == tdp_pkg::PH_DONE);

    // phase only moves forward on control ticks
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && mode_reg != M_START) |=> profile_phase_reg >= $past(profile_phase_reg))
        else $error("profile phase moved backward on a control tick");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide step");

    // no new word while the divider is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> !in_ready)
        else $error("input taken while divider busy");

    // cruise always drives at peak
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && phase == tdp_pkg::PH_CRUISE) |->
            (left_drive == 8'sd127 || left_drive == -8'sd127))
        else $error("cruise command is not at peak");

    // a start word is answered with the drive stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && mode_reg == M_START) |=> (left_drive == 8'sd0 && right_drive == 8'sd0))
        else $error("start word produced a nonzero command");

endmodule

FILE: src/tdp_div.sv
// restoring divider, one quotient bit per cycle
module tdp_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [tdp_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [tdp_pkg::DIVISOR_W-1:0]    divisor,
    output logic [tdp_pkg::DIVIDEND_W-1:0]   quotient,
    output tdp_pkg::div_stat_t               stat
);

    localparam int STEPS = tdp_pkg::DIVIDEND_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int DV_W  = tdp_pkg::DIVISOR_W;

    logic [tdp_pkg::DIVIDEND_W-1:0] work_reg;
    logic [DV_W-1:0]                rem_reg;
    logic [DV_W-1:0]                dvs_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [DV_W:0]   trial;
    logic [DV_W+1:0] diff;
    logic            fits;
    logic [DV_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, work_reg[tdp_pkg::DIVIDEND_W-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        fits     = !diff[DV_W+1];
        rem_next = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // pulses on the edge that shifts in the last quotient bit
            done_reg <= busy_reg && (cnt_reg == CNT_W'(STEPS - 1));
            if (start && !busy_reg)
            begin
                work_reg <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg <= {work_reg[tdp_pkg::DIVIDEND_W-2:0], fits};
                rem_reg  <= rem_next;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    assign quotient  = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: verif/drive_profile_check.sv
// drive profile scoreboard: mirrors the registers, predicts every drive word and checks the output
`timescale 1ns / 100ps
module drive_profile_check (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tdp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tdp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              action,
    input  logic signed [tdp_pkg::ENC_W-1:0]  enc_left_front,
    input  logic signed [tdp_pkg::ENC_W-1:0]  enc_left_back,
    input  logic signed [tdp_pkg::ENC_W-1:0]  enc_right_front,
    input  logic signed [tdp_pkg::ENC_W-1:0]  enc_right_back,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [7:0]                 left_drive,
    input  logic signed [7:0]                 right_drive,
    input  logic [1:0]                        phase,
    input  logic                              done_res,
    output int                                mismatches,
    output int                                waiting
);

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic [1:0]        ph;
        logic              fin;
    } drive_word_t;

    logic [tdp_pkg::TARGET_W-1:0] goal_ticks;
    logic                         reverse_dir;
    logic [tdp_pkg::RAMP_W-1:0]   span_ticks;
    logic [tdp_pkg::BREAK_W-1:0]  stop_speed;
    logic                         spin_mode;
    logic                         spin_cw;
    tdp_pkg::phase_t              profile_ph;
    drive_word_t                  drive_q[$];
    int                           fail_cnt = 0;

    assign mismatches = fail_cnt;

    function automatic longint enc_mag(input logic signed [tdp_pkg::ENC_W-1:0] raw);
        longint v;
        v = longint'(raw);
        return (v < 0) ? -v : v;
    endfunction

    // advances the profile phase and returns the drive word for one input word
    function automatic drive_word_t predict_drive(input logic act,
                                                  input logic signed [tdp_pkg::ENC_W-1:0] lf,
                                                  input logic signed [tdp_pkg::ENC_W-1:0] lb,
                                                  input logic signed [tdp_pkg::ENC_W-1:0] rf,
                                                  input logic signed [tdp_pkg::ENC_W-1:0] rb);
        drive_word_t w;
        longint      travel;
        longint      goal4;
        longint      span4;
        longint      mag;
        longint      cmd;
        longint      dir;
        longint      lcmd;
        longint      rcmd;
        logic        moving;
        w = '0;
        mag = 0;
        moving = 1'b0;
        if (!act) begin
            profile_ph = tdp_pkg::PH_ACCEL;
            w.ph = tdp_pkg::PH_ACCEL;
            return w;
        end
        // sum of magnitudes is four times the mean travel, so limits are scaled by four
        travel = enc_mag(lf) + enc_mag(lb) + enc_mag(rf) + enc_mag(rb);
        goal4 = longint'(goal_ticks);
        goal4 = goal4 * 4;
        span4 = (span_ticks == '0) ? 64'sd1 : longint'(span_ticks);
        span4 = span4 * 4;
        if (profile_ph == tdp_pkg::PH_ACCEL) begin
            if (travel < span4 && 2 * travel <= goal4) begin
                mag = longint'(tdp_pkg::INIT_CMD)
                      + travel * longint'(tdp_pkg::RAMP_GAIN) / span4;
                moving = 1'b1;
            end
            else
                profile_ph = tdp_pkg::PH_CRUISE;
        end
        if (!moving && profile_ph == tdp_pkg::PH_CRUISE) begin
            if (travel + span4 <= goal4) begin
                mag = longint'(tdp_pkg::PEAK_CMD);
                moving = 1'b1;
            end
            else
                profile_ph = tdp_pkg::PH_DECEL;
        end
        if (!moving && profile_ph == tdp_pkg::PH_DECEL) begin
            if (travel < goal4) begin
                mag = (goal4 - travel) * longint'(tdp_pkg::RAMP_GAIN) / span4;
                if (mag <= longint'(stop_speed))
                    profile_ph = tdp_pkg::PH_DONE;
                else
                    moving = 1'b1;
            end
            else
                profile_ph = tdp_pkg::PH_DONE;
        end
        w.ph = profile_ph;
        w.fin = (profile_ph == tdp_pkg::PH_DONE);
        if (moving) begin
            cmd = reverse_dir ? mag : -mag;
            dir = spin_cw ? 64'sd1 : -64'sd1;
            if (spin_mode) begin
                lcmd = -cmd * dir;
                rcmd = cmd * dir;
            end
            else begin
                lcmd = cmd;
                rcmd = cmd;
            end
            w.left = lcmd[7:0];
            w.right = rcmd[7:0];
        end
        return w;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        drive_word_t want;
        drive_word_t got;
        if (!rst_n) begin
            goal_ticks = '0;
            reverse_dir = 1'b0;
            span_ticks = tdp_pkg::RAMP_W'(1);
            stop_speed = tdp_pkg::BREAK_RESET;
            spin_mode = 1'b0;
            spin_cw = 1'b1;
            profile_ph = tdp_pkg::PH_DONE;
            drive_q.delete();
            waiting <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                got = {left_drive, right_drive, phase, done_res};
                if (drive_q.size() == 0) begin
                    $display("%0t: drive word with nothing expected: left %0d right %0d %s %0d %s %0d",
                             $time, left_drive, right_drive, "phase", phase, "done", done_res);
                    fail_cnt++;
                end
                else begin
                    want = drive_q.pop_front();
                    compare_field("left_drive", int'(want.left), int'(got.left));
                    compare_field("right_drive", int'(want.right), int'(got.right));
                    compare_field("phase", int'(want.ph), int'(got.ph));
                    compare_field("done_res", int'(want.fin), int'(got.fin));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    tdp_pkg::REG_TARGET:    goal_ticks = cfg_wdata[tdp_pkg::TARGET_W-1:0];
                    tdp_pkg::REG_REVERSE:   reverse_dir = cfg_wdata[0];
                    tdp_pkg::REG_RAMP:      span_ticks = cfg_wdata[tdp_pkg::RAMP_W-1:0];
                    tdp_pkg::REG_BREAK:     stop_speed = cfg_wdata[tdp_pkg::BREAK_W-1:0];
                    tdp_pkg::REG_TURN_MODE: spin_mode = cfg_wdata[0];
                    tdp_pkg::REG_TURN_CW:   spin_cw = cfg_wdata[0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
                drive_q.push_back(predict_drive(action, enc_left_front, enc_left_back,
                                                enc_right_front, enc_right_back));
            waiting <= drive_q.size();
        end
    end

endmodule

FILE: verif/tb_trapezoid_drive_profile_top.sv
// trapezoid drive profile testbench: clock, reset, stimulus, flow control and verdict
`timescale 1ns / 100ps
module tb_trapezoid_drive_profile_top;

    localparam int     ITEM_GOAL   = 1050;
    localparam int     CALM_AFTER  = 950;
    localparam int     LONG_STALL  = 250;
    localparam longint ENC_MAX_MAG = 524288;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [tdp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tdp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic                           action = 1'b0;
    logic signed [tdp_pkg::ENC_W-1:0] enc_left_front = '0;
    logic signed [tdp_pkg::ENC_W-1:0] enc_left_back = '0;
    logic signed [tdp_pkg::ENC_W-1:0] enc_right_front = '0;
    logic signed [tdp_pkg::ENC_W-1:0] enc_right_back = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [7:0]              left_drive;
    logic signed [7:0]              right_drive;
    logic [1:0]                     phase;
    logic                           done_res;
    int                             mismatches;
    int                             waiting;

    int words_sent = 0;
    bit calm = 1'b0;
    bit burst = 1'b0;
    bit long_stall_req = 1'b0;
    bit long_stall_done = 1'b0;

    trapezoid_drive_profile_top DUT (.*);

    drive_profile_check drive_check (.*);

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output side: short random holds, or one long hold on request
    always begin
        @(posedge clk);
        if (long_stall_req && !long_stall_done) begin
            out_ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clk);
            long_stall_done = 1'b1;
            out_ready <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(posedge clk);
        end
        else
            out_ready <= 1'b1;
    end

    function automatic logic signed [tdp_pkg::ENC_W-1:0] rnd_enc();
        logic [31:0] r;
        r = $urandom;
        return r[tdp_pkg::ENC_W-1:0];
    endfunction

    // encoder reading of a given magnitude with a random sign (always negative at the largest magnitude)
    function automatic logic signed [tdp_pkg::ENC_W-1:0] enc_at(input longint mag);
        longint v;
        v = (mag > ENC_MAX_MAG) ? ENC_MAX_MAG : mag;
        if (v < 0)
            v = 0;
        if (v == ENC_MAX_MAG || $urandom_range(0, 1) == 1)
            v = -v;
        return v[tdp_pkg::ENC_W-1:0];
    endfunction

    task automatic offer_word(input logic act,
                              input logic signed [tdp_pkg::ENC_W-1:0] lf,
                              input logic signed [tdp_pkg::ENC_W-1:0] lb,
                              input logic signed [tdp_pkg::ENC_W-1:0] rf,
                              input logic signed [tdp_pkg::ENC_W-1:0] rb);
        in_valid <= 1'b1;
        action <= act;
        enc_left_front <= lf;
        enc_left_back <= lb;
        enc_right_front <= rf;
        enc_right_back <= rb;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if (!calm && !burst && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic start_word();
        offer_word(1'b0, rnd_enc(), rnd_enc(), rnd_enc(), rnd_enc());
    endtask

    // control tick with every wheel near travel p
    task automatic tick_at(input longint p, input int jit);
        longint m[4];
        for (int i = 0; i < 4; i++) begin
            m[i] = longint'($urandom_range(0, 2 * jit));
            m[i] = m[i] + p - longint'(jit);
        end
        offer_word(1'b1, enc_at(m[0]), enc_at(m[1]), enc_at(m[2]), enc_at(m[3]));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
    endtask

    task automatic write_reg(input logic [tdp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tdp_pkg::CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic set_profile(input logic [tdp_pkg::TARGET_W-1:0] goal, input logic rev,
                               input logic [tdp_pkg::RAMP_W-1:0] span,
                               input logic [tdp_pkg::BREAK_W-1:0] brk,
                               input logic spin, input logic cw);
        drain();
        write_reg(tdp_pkg::REG_TARGET, goal);
        write_reg(tdp_pkg::REG_REVERSE, tdp_pkg::CFG_DATA_W'(rev));
        write_reg(tdp_pkg::REG_RAMP, tdp_pkg::CFG_DATA_W'(span));
        write_reg(tdp_pkg::REG_BREAK, tdp_pkg::CFG_DATA_W'(brk));
        write_reg(tdp_pkg::REG_TURN_MODE, tdp_pkg::CFG_DATA_W'(spin));
        write_reg(tdp_pkg::REG_TURN_CW, tdp_pkg::CFG_DATA_W'(cw));
        cfg_we <= 1'b0;
    endtask

    task automatic random_profile(output longint goal);
        logic [tdp_pkg::TARGET_W-1:0] tgt;
        logic [tdp_pkg::RAMP_W-1:0]   span;
        logic [tdp_pkg::BREAK_W-1:0]  brk;
        case ($urandom_range(0, 9))
            0: begin
                tgt = ($urandom_range(0, 1) == 1) ? '1 : '0;
                case ($urandom_range(0, 2))
                    0:       span = '0;
                    1:       span = tdp_pkg::RAMP_W'(1);
                    default: span = '1;
                endcase
                brk = ($urandom_range(0, 1) == 1) ? '1 : '0;
            end
            1: begin
                tgt = tdp_pkg::TARGET_W'($urandom_range(0, 1048575));
                span = tdp_pkg::RAMP_W'($urandom_range(0, 65535));
                brk = tdp_pkg::BREAK_W'($urandom_range(0, 127));
            end
            default: begin
                tgt = tdp_pkg::TARGET_W'($urandom_range(0, 3000));
                span = tdp_pkg::RAMP_W'($urandom_range(1, 1200));
                brk = tdp_pkg::BREAK_W'($urandom_range(0, 110));
            end
        endcase
        set_profile(tgt, $urandom_range(0, 1) == 1, span, brk, $urandom_range(0, 1) == 1,
                    $urandom_range(0, 1) == 1);
        goal = longint'(tgt);
    endtask

    // one move: start word, then ticks with travel rising toward a point past the target
    task automatic run_move(input longint goal);
        longint p;
        longint reach;
        int     stride;
        int     n;
        n = $urandom_range(12, 32);
        reach = goal + goal / 8 + 8;
        if (reach > ENC_MAX_MAG + 8)
            reach = ENC_MAX_MAG + 8;
        stride = int'(reach / longint'(n)) + 1;
        p = 0;
        // now and then the ticks come without a start word
        if ($urandom_range(0, 11) != 0)
            start_word();
        for (int k = 0; k <= n; k++) begin
            case ($urandom_range(0, 49))
                0:       start_word();
                1, 2:    offer_word(1'b1, rnd_enc(), rnd_enc(), rnd_enc(), rnd_enc());
                default: tick_at(p, 2);
            endcase
            p = p + longint'($urandom_range(0, 2 * stride));
        end
    endtask

    initial begin : stimulus
        longint goal;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: tick while done, then a zero target
        offer_word(1'b1, 20'h80000, 20'h7FFFF, 20'h00000, 20'hFFFFF);
        start_word();
        tick_at(0, 0);

        // full profile: ramp up, cruise, ramp down, stop below the break speed
        set_profile(1000, 1'b0, 100, 30, 1'b0, 1'b1);
        start_word();
        tick_at(0, 0);
        tick_at(50, 0);
        tick_at(100, 0);
        tick_at(500, 0);
        tick_at(950, 0);
        tick_at(980, 0);
        tick_at(990, 0);
        // already at the target on the first tick
        start_word();
        tick_at(1000, 0);

        // reverse, counterclockwise turn, highest break speed
        set_profile(1000, 1'b1, 100, 127, 1'b1, 1'b0);
        start_word();
        tick_at(0, 0);
        tick_at(400, 0);
        tick_at(950, 0);

        // largest target and span, clockwise turn, largest encoder magnitude
        set_profile(20'hFFFFF, 1'b1, 16'hFFFF, 0, 1'b1, 1'b1);
        start_word();
        tick_at(ENC_MAX_MAG, 0);

        // zero ramp span acts as one
        set_profile(10, 1'b0, 0, 0, 1'b0, 1'b1);
        start_word();
        tick_at(1, 0);

        // output held off while words keep coming
        set_profile(2000, 1'b0, 300, 40, 1'b0, 1'b1);
        long_stall_req = 1'b1;
        burst = 1'b1;
        run_move(2000);
        burst = 1'b0;

        while (words_sent < ITEM_GOAL) begin
            if (words_sent >= CALM_AFTER)
                calm = 1'b1;
            random_profile(goal);
            repeat ($urandom_range(1, 3)) run_move(goal);
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("** trapezoid_drive_profile_top: PASSED **");
        else
            $display("** trapezoid_drive_profile_top: FAILED **");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("** trapezoid_drive_profile_top: FAILED **");
        $finish;
    end

endmodule
